>>> rtl/sdinit_pkg.sv
// Package for the SD/MMC card initialisation sequencer.
// Holds the item and result types, the phase and code enums and the command constants.
// No dependencies.
`default_nettype none

package sdinit_pkg;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DONE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  // Response kinds of an issued command
  typedef enum logic [1:0] {
    RSP_NONE  = 2'd0,
    RSP_SHORT = 2'd1,
    RSP_LONG  = 2'd2
  } resp_kind_e;

  // Reported initialisation status
  typedef enum logic [1:0] {
    STAT_IDLE   = 2'd0,
    STAT_BUSY   = 2'd1,
    STAT_READY  = 2'd2,
    STAT_FAILED = 2'd3
  } status_e;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_V2     = 4'd3,
    PH_PROBE  = 4'd4,
    PH_V1     = 4'd5,
    PH_CMD2   = 4'd6,
    PH_CMD3   = 4'd7,
    PH_CMD9   = 4'd8,
    PH_CMD7   = 4'd9,
    PH_CMD16  = 4'd10,
    PH_READY  = 4'd11,
    PH_FAILED = 4'd12
  } phase_e;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT  = 1'b0;
  localparam logic CFG_BLOCKLEN = 1'b1;

  // Register reset values
  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic [11:0] BLOCKLEN_RESET = 12'd512;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_OP   = 6'd1;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SET_RCA   = 6'd3;
  localparam logic [5:0] CMD_SELECT    = 6'd7;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
  localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
  localparam logic [5:0] CMD_APP_OP    = 6'd41;
  localparam logic [5:0] CMD_APP_CMD   = 6'd55;

  // Command arguments and response masks
  localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
  localparam logic [11:0] IF_COND_ECHO  = 12'h1AA;
  localparam logic [31:0] ARG_OCR_HCS   = 32'h40FF_8000;
  localparam logic [31:0] ARG_OCR       = 32'h00FF_8000;
  localparam logic [31:0] ARG_MMC_RCA   = 32'h0001_0000;
  localparam logic [31:0] R1_ERR_MASK   = 32'hFDF9_0000;

  // Bit positions in responses
  localparam int unsigned APP_CMD_BIT = 5;
  localparam int unsigned OCR_BUSY    = 31;
  localparam int unsigned OCR_CCS     = 30;

  // Card kind bits
  localparam logic [3:0] KIND_MMC   = 4'b0001;
  localparam logic [3:0] KIND_SD1   = 4'b0010;
  localparam logic [3:0] KIND_SD2   = 4'b0100;
  localparam logic [3:0] KIND_BLOCK = 4'b1000;

  typedef struct packed {
    logic [1:0]  action;
    logic        cmd_sent;
    logic        resp_timeout;
    logic        crc_fail;
    logic        resp_received;
    logic [31:0] resp_word;
  } item_t;

  typedef struct packed {
    logic        issue_cmd;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic [1:0]  init_status;
    logic [3:0]  card_kind;
    logic [15:0] card_address;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/sdinit_if.sv
// Valid/ready channel interfaces for the card initialisation sequencer.
// One interface for input items and one for results; no dependencies.
`default_nettype none

interface sdinit_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        cmd_sent;
  logic        resp_timeout;
  logic        crc_fail;
  logic        resp_received;
  logic [31:0] resp_word;

  modport source (
    output valid, action, cmd_sent, resp_timeout, crc_fail, resp_received, resp_word,
    input  ready
  );
  modport sink (
    input  valid, action, cmd_sent, resp_timeout, crc_fail, resp_received, resp_word,
    output ready
  );
endinterface

interface sdinit_out_if;
  logic        valid;
  logic        ready;
  logic        issue_cmd;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_arg;
  logic [1:0]  resp_kind;
  logic [1:0]  init_status;
  logic [3:0]  card_kind;
  logic [15:0] card_address;

  modport source (
    output valid, issue_cmd, cmd_index, cmd_arg, resp_kind, init_status, card_kind,
           card_address,
    input  ready
  );
  modport sink (
    input  valid, issue_cmd, cmd_index, cmd_arg, resp_kind, init_status, card_kind,
           card_address,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sdinit_ctrl.sv
// Sequencer state and decision logic for card identification.
// Depends on sdinit_pkg; produces one result per processed transaction.
`default_nettype none

module sdinit_ctrl #(
  parameter int unsigned ELAPSED_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  sdinit_pkg::item_t    item_i,
  input  wire  [15:0]          timeout_i,
  input  wire  [11:0]          blk_len_i,
  output sdinit_pkg::result_t  result_o
);

  localparam int unsigned CmpW = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;
  localparam logic [ELAPSED_BITS-1:0] ElMax = {ELAPSED_BITS{1'b1}};

  sdinit_pkg::phase_e        phase_q, phase_d;
  logic [3:0]                kind_q, kind_d;
  logic [15:0]               rca_q, rca_d;
  logic [ELAPSED_BITS-1:0]   el_q, el_d;
  logic                      pend_q, pend_d;
  logic                      cmd1_q, cmd1_d;

  logic                      busy;
  logic                      ok_plain;
  logic                      ok_tol;
  logic                      prefix_ok;
  logic                      el_sat;
  logic                      el_below;
  logic                      el_above;
  logic [31:0]               w;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdinit_pkg::PH_IDLE;
      kind_q  <= '0;
      rca_q   <= '0;
      el_q    <= '0;
      pend_q  <= 1'b0;
      cmd1_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      rca_q   <= rca_d;
      el_q    <= el_d;
      pend_q  <= pend_d;
      cmd1_q  <= cmd1_d;
    end
  end

  // Completion judgement; a CRC error is tolerated for the polling commands only.
  assign w         = item_i.resp_word;
  assign ok_plain  = !item_i.resp_timeout && !item_i.crc_fail;
  assign ok_tol    = !item_i.resp_timeout;
  assign prefix_ok = ok_plain && w[sdinit_pkg::APP_CMD_BIT];
  assign busy      = (phase_q != sdinit_pkg::PH_IDLE) && (phase_q != sdinit_pkg::PH_READY) &&
                     (phase_q != sdinit_pkg::PH_FAILED);

  // Timeout comparisons against the polling budget
  assign el_sat   = (el_q == ElMax);
  assign el_below = (CmpW'(el_q) < CmpW'(timeout_i)) && !el_sat;
  assign el_above = (CmpW'(el_q) > CmpW'(timeout_i)) || el_sat;

  // Next state and the command to issue
  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    rca_d    = rca_q;
    el_d     = el_q;
    pend_d   = pend_q;
    cmd1_d   = cmd1_q;
    result_o = '0;

    case (item_i.action)
      sdinit_pkg::ACT_START: begin
        phase_d            = sdinit_pkg::PH_CMD0;
        el_d               = '0;
        pend_d             = 1'b0;
        result_o.issue_cmd = 1'b1;
        result_o.cmd_index = sdinit_pkg::CMD_GO_IDLE;
        result_o.resp_kind = sdinit_pkg::RSP_NONE;
      end
      sdinit_pkg::ACT_TICK: begin
        if (busy && !el_sat) begin
          el_d = el_q + 1'b1;
        end
      end
      sdinit_pkg::ACT_DONE: begin
        if (busy) begin
          case (phase_q)
            sdinit_pkg::PH_CMD0: begin
              el_d               = '0;
              phase_d            = sdinit_pkg::PH_CMD8;
              result_o.issue_cmd = 1'b1;
              result_o.cmd_index = sdinit_pkg::CMD_IF_COND;
              result_o.cmd_arg   = sdinit_pkg::ARG_IF_COND;
              result_o.resp_kind = sdinit_pkg::RSP_SHORT;
            end
            sdinit_pkg::PH_CMD8: begin
              if (ok_plain && (w[11:0] == sdinit_pkg::IF_COND_ECHO)) begin
                kind_d  = '0;
                phase_d = sdinit_pkg::PH_V2;
              end else begin
                phase_d = sdinit_pkg::PH_PROBE;
              end
              pend_d             = 1'b1;
              result_o.issue_cmd = 1'b1;
              result_o.cmd_index = sdinit_pkg::CMD_APP_CMD;
              result_o.cmd_arg   = {rca_q, 16'h0000};
              result_o.resp_kind = sdinit_pkg::RSP_SHORT;
            end
            sdinit_pkg::PH_V2: begin
              pend_d = 1'b0;
              if (pend_q && prefix_ok) begin
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_APP_OP;
                result_o.cmd_arg   = sdinit_pkg::ARG_OCR_HCS;
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end else if (!pend_q && ok_tol && w[sdinit_pkg::OCR_BUSY]) begin
                kind_d = w[sdinit_pkg::OCR_CCS] ? (sdinit_pkg::KIND_SD2 | sdinit_pkg::KIND_BLOCK)
                                                : sdinit_pkg::KIND_SD2;
                phase_d            = sdinit_pkg::PH_CMD2;
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_ALL_CID;
                result_o.resp_kind = sdinit_pkg::RSP_LONG;
              end else if (el_below) begin
                pend_d             = 1'b1;
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_APP_CMD;
                result_o.cmd_arg   = {rca_q, 16'h0000};
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end else begin
                phase_d = sdinit_pkg::PH_FAILED;
              end
            end
            sdinit_pkg::PH_PROBE: begin
              pend_d = 1'b0;
              if (pend_q && prefix_ok) begin
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_APP_OP;
                result_o.cmd_arg   = sdinit_pkg::ARG_OCR;
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end else if (!pend_q && ok_tol) begin
                // The card answered ACMD41: an SD v1 card
                kind_d             = sdinit_pkg::KIND_SD1;
                cmd1_d             = 1'b0;
                phase_d            = sdinit_pkg::PH_V1;
                pend_d             = 1'b1;
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_APP_CMD;
                result_o.cmd_arg   = {rca_q, 16'h0000};
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end else begin
                // No answer to the app command: treat it as an MMC card
                kind_d             = sdinit_pkg::KIND_MMC;
                cmd1_d             = 1'b1;
                phase_d            = sdinit_pkg::PH_V1;
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_SEND_OP;
                result_o.cmd_arg   = sdinit_pkg::ARG_OCR;
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end
            end
            sdinit_pkg::PH_V1: begin
              pend_d = 1'b0;
              if (pend_q && prefix_ok) begin
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_APP_OP;
                result_o.cmd_arg   = sdinit_pkg::ARG_OCR;
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end else if (!pend_q && ok_tol && w[sdinit_pkg::OCR_BUSY]) begin
                phase_d            = sdinit_pkg::PH_CMD2;
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_ALL_CID;
                result_o.resp_kind = sdinit_pkg::RSP_LONG;
              end else if (el_above) begin
                phase_d = sdinit_pkg::PH_FAILED;
              end else if (cmd1_q) begin
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_SEND_OP;
                result_o.cmd_arg   = sdinit_pkg::ARG_OCR;
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end else begin
                pend_d             = 1'b1;
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_APP_CMD;
                result_o.cmd_arg   = {rca_q, 16'h0000};
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end
            end
            sdinit_pkg::PH_CMD2: begin
              if (!ok_plain) begin
                phase_d = sdinit_pkg::PH_FAILED;
                pend_d  = 1'b0;
              end else begin
                phase_d            = sdinit_pkg::PH_CMD3;
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_SET_RCA;
                result_o.cmd_arg   = ((kind_q & (sdinit_pkg::KIND_SD1 | sdinit_pkg::KIND_SD2))
                                      != '0) ? 32'h0 : sdinit_pkg::ARG_MMC_RCA;
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end
            end
            sdinit_pkg::PH_CMD3: begin
              if (!ok_plain) begin
                phase_d = sdinit_pkg::PH_FAILED;
                pend_d  = 1'b0;
              end else begin
                rca_d = ((kind_q & (sdinit_pkg::KIND_SD1 | sdinit_pkg::KIND_SD2)) != '0)
                        ? w[31:16] : 16'd1;
                phase_d            = sdinit_pkg::PH_CMD9;
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_SEND_CSD;
                result_o.cmd_arg   = {rca_d, 16'h0000};
                result_o.resp_kind = sdinit_pkg::RSP_LONG;
              end
            end
            sdinit_pkg::PH_CMD9: begin
              if (!ok_plain) begin
                phase_d = sdinit_pkg::PH_FAILED;
                pend_d  = 1'b0;
              end else begin
                phase_d            = sdinit_pkg::PH_CMD7;
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_SELECT;
                result_o.cmd_arg   = {rca_q, 16'h0000};
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end
            end
            sdinit_pkg::PH_CMD7: begin
              if (!ok_plain) begin
                phase_d = sdinit_pkg::PH_FAILED;
                pend_d  = 1'b0;
              end else if ((kind_q & sdinit_pkg::KIND_BLOCK) != '0) begin
                phase_d = sdinit_pkg::PH_READY;
              end else begin
                phase_d            = sdinit_pkg::PH_CMD16;
                result_o.issue_cmd = 1'b1;
                result_o.cmd_index = sdinit_pkg::CMD_BLOCKLEN;
                result_o.cmd_arg   = {20'h00000, blk_len_i};
                result_o.resp_kind = sdinit_pkg::RSP_SHORT;
              end
            end
            sdinit_pkg::PH_CMD16: begin
              if (ok_plain && ((w & sdinit_pkg::R1_ERR_MASK) == '0)) begin
                phase_d = sdinit_pkg::PH_READY;
              end else begin
                phase_d = sdinit_pkg::PH_FAILED;
                pend_d  = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    // Status and card identity after this transaction
    case (phase_d)
      sdinit_pkg::PH_IDLE:   result_o.init_status = sdinit_pkg::STAT_IDLE;
      sdinit_pkg::PH_READY:  result_o.init_status = sdinit_pkg::STAT_READY;
      sdinit_pkg::PH_FAILED: result_o.init_status = sdinit_pkg::STAT_FAILED;
      default:               result_o.init_status = sdinit_pkg::STAT_BUSY;
    endcase
    result_o.card_kind    = kind_d;
    result_o.card_address = rca_d;
  end

`ifndef SYNTH
  // An app command prefix is only outstanding during operating condition polling.
  a_pend_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (phase_q == sdinit_pkg::PH_V2 || phase_q == sdinit_pkg::PH_PROBE ||
                phase_q == sdinit_pkg::PH_V1))
    else $error("app prefix pending outside a polling phase");

  // A start transaction always restarts the sequence at CMD0.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.action == sdinit_pkg::ACT_START) |=> (phase_q == sdinit_pkg::PH_CMD0))
    else $error("start did not restart the sequence");

  // A command is only ever issued while the sequence is busy.
  a_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.issue_cmd) |-> (result_o.init_status == sdinit_pkg::STAT_BUSY))
    else $error("command issued outside busy");

  // Polling with CMD1 belongs to an MMC card.
  a_cmd1_mmc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sdinit_pkg::PH_V1 && cmd1_q) |-> (kind_q == sdinit_pkg::KIND_MMC))
    else $error("CMD1 polling without MMC kind");

  // The millisecond count moves only with a processed transaction.
  a_el_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(el_q))
    else $error("elapsed count changed without a transaction");
`endif

endmodule

`default_nettype wire

>>> rtl/sd_card_init_sequencer.sv
// Top level of the SD/MMC card initialisation sequencer.
// Depends on sdinit_pkg, sdinit_if and sdinit_ctrl.
`default_nettype none

// The sequencer takes one transaction per clock cycle while the sink keeps up and
// returns exactly one result for each: the transaction is captured in an input
// register, the decision logic of sdinit_ctrl updates the card state in one pass,
// and the result is held in an output register until the sink takes it.
// While the sink stalls, the input register absorbs one further transaction before
// ready drops. A start transaction issues CMD0 and every result carries the command
// to issue next, if any, along with status, card kind and relative card address.
// Configuration writes are taken at any edge with cfg_we_i high and must only be
// made while no transaction is in flight.
module sd_card_init_sequencer #(
  parameter int unsigned ELAPSED_BITS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire               cfg_index_i,
  input  wire  [15:0]       cfg_wdata_i,
  sdinit_in_if.sink         item_i,
  sdinit_out_if.source      result_o
);

  logic                 in_vld_q;
  sdinit_pkg::item_t    item_q;
  logic                 out_vld_q, out_vld_d;
  sdinit_pkg::result_t  res_q, res_d;
  logic [15:0]          timeout_q;
  logic [11:0]          blk_len_q;
  logic                 step;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= sdinit_pkg::TIMEOUT_RESET;
      blk_len_q <= sdinit_pkg::BLOCKLEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sdinit_pkg::CFG_TIMEOUT:  timeout_q <= cfg_wdata_i;
        sdinit_pkg::CFG_BLOCKLEN: blk_len_q <= cfg_wdata_i[11:0];
        default: begin
        end
      endcase
    end
  end

  // A transaction is processed when the result register is free or being emptied.
  assign step         = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      in_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.action        <= item_i.action;
      item_q.cmd_sent      <= item_i.cmd_sent;
      item_q.resp_timeout  <= item_i.resp_timeout;
      item_q.crc_fail      <= item_i.crc_fail;
      item_q.resp_received <= item_i.resp_received;
      item_q.resp_word     <= item_i.resp_word;
    end
  end

  sdinit_ctrl #(
    .ELAPSED_BITS(ELAPSED_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .timeout_i(timeout_q),
    .blk_len_i(blk_len_q),
    .result_o (res_d)
  );

  // Result register
  always_comb begin
    if (step) begin
      out_vld_d = 1'b1;
    end else if (result_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.issue_cmd    = res_q.issue_cmd;
  assign result_o.cmd_index    = res_q.cmd_index;
  assign result_o.cmd_arg      = res_q.cmd_arg;
  assign result_o.resp_kind    = res_q.resp_kind;
  assign result_o.init_status  = res_q.init_status;
  assign result_o.card_kind    = res_q.card_kind;
  assign result_o.card_address = res_q.card_address;

endmodule

`default_nettype wire
